[design/aligned_watermark_alpha_blend_top_assert.svh]
// ----------------------------------------------------------------------------
// aligned watermark alpha blend - assertion macros
// shared property shapes for the port-level checker
// ----------------------------------------------------------------------------
`ifndef ALIGNED_WATERMARK_ALPHA_BLEND_TOP_ASSERT_SVH
`define ALIGNED_WATERMARK_ALPHA_BLEND_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define AWAB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define AWAB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/awab_pkg.sv]
// ----------------------------------------------------------------------------
// awab_pkg
// shared types, register codes and blend constants
// ----------------------------------------------------------------------------
package awab_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;

    localparam int CFG_DIM_W  = 13;
    localparam int ALIGN_W    = 2;
    localparam int OPACITY_W  = 7;
    localparam int OPACITY_MAX = 100;
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // blend weight alpha*opacity, at most 255*100
    localparam int WEIGHT_W   = 15;
    localparam logic [WEIGHT_W-1:0] FULL_SCALE = WEIGHT_W'(25500);

    // floor(p / 25500) as (p * RECIP) >> SHIFT, exact for p < 2**PROD_W
    localparam int PROD_W  = PIX_W + WEIGHT_W;
    localparam int SHIFT   = PROD_W + 15;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << SHIFT) + 64'd25500 - 64'd1) / 64'd25500;
    localparam int RECIP_W = PROD_W + 1;
    localparam int QMUL_W  = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    typedef enum logic [2:0] {
        REG_PHOTO_WIDTH     = 3'd0,
        REG_PHOTO_HEIGHT    = 3'd1,
        REG_MARK_WIDTH      = 3'd2,
        REG_MARK_HEIGHT     = 3'd3,
        REG_ALIGN_HORIZONTAL = 3'd4,
        REG_ALIGN_VERTICAL  = 3'd5,
        REG_OPACITY_PERCENT = 3'd6
    } reg_index_t;

    typedef enum logic [ALIGN_W-1:0] {
        ALIGN_START = 2'd0,
        ALIGN_MID   = 2'd1,
        ALIGN_TAIL  = 2'd2
    } align_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] photo_width;
        logic [CFG_DIM_W-1:0] photo_height;
        logic [CFG_DIM_W-1:0] mark_width;
        logic [CFG_DIM_W-1:0] mark_height;
        logic [ALIGN_W-1:0]   align_horizontal;
        logic [ALIGN_W-1:0]   align_vertical;
        logic [OPACITY_W-1:0] opacity_percent;
    } awab_cfg_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] lo;
        logic [CFG_DIM_W-1:0] hi;
    } axis_win_t;

    typedef struct packed {
        axis_win_t x;
        axis_win_t y;
    } window_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

[design/awab_cfg.sv]
// ----------------------------------------------------------------------------
// awab_cfg
// apb register file with saturation of dimensions and opacity
// ----------------------------------------------------------------------------
module awab_cfg import awab_pkg::*; #(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output awab_cfg_t             cfg
);

    localparam int DIM_NEED = $clog2(MAX_DIMENSION + 1);
    localparam int DIM_W    = (DIM_NEED < CFG_DIM_W) ? DIM_NEED : CFG_DIM_W;

    logic [DIM_W-1:0]     photo_w_reg, photo_h_reg, mark_w_reg, mark_h_reg;
    logic [ALIGN_W-1:0]   align_h_reg, align_v_reg;
    logic [OPACITY_W-1:0] opacity_reg;
    logic                 wr_en;
    reg_index_t           wr_index;
    logic [DIM_W-1:0]     dim_sat;
    logic [OPACITY_W-1:0] opacity_sat;

    assign wr_en    = psel && penable && pwrite;
    assign wr_index = reg_index_t'(paddr[APB_ADDR_W-1:2]);

    // dimensions above the limit clamp to it
    assign dim_sat = (int'(pwdata[CFG_DIM_W-1:0]) > MAX_DIMENSION)
                   ? DIM_W'(MAX_DIMENSION) : DIM_W'(pwdata[CFG_DIM_W-1:0]);
    assign opacity_sat = (int'(pwdata[OPACITY_W-1:0]) > OPACITY_MAX)
                       ? OPACITY_W'(OPACITY_MAX) : pwdata[OPACITY_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            photo_w_reg <= DIM_W'(1);
            photo_h_reg <= DIM_W'(1);
            mark_w_reg  <= DIM_W'(1);
            mark_h_reg  <= DIM_W'(1);
            align_h_reg <= ALIGN_START;
            align_v_reg <= ALIGN_START;
            opacity_reg <= OPACITY_W'(OPACITY_MAX);
        end else if (wr_en) begin
            case (wr_index)
                REG_PHOTO_WIDTH:      photo_w_reg <= dim_sat;
                REG_PHOTO_HEIGHT:     photo_h_reg <= dim_sat;
                REG_MARK_WIDTH:       mark_w_reg  <= dim_sat;
                REG_MARK_HEIGHT:      mark_h_reg  <= dim_sat;
                REG_ALIGN_HORIZONTAL: align_h_reg <= pwdata[ALIGN_W-1:0];
                REG_ALIGN_VERTICAL:   align_v_reg <= pwdata[ALIGN_W-1:0];
                REG_OPACITY_PERCENT:  opacity_reg <= opacity_sat;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.photo_width      = CFG_DIM_W'(photo_w_reg);
        cfg.photo_height     = CFG_DIM_W'(photo_h_reg);
        cfg.mark_width       = CFG_DIM_W'(mark_w_reg);
        cfg.mark_height      = CFG_DIM_W'(mark_h_reg);
        cfg.align_horizontal = align_h_reg;
        cfg.align_vertical   = align_v_reg;
        cfg.opacity_percent  = opacity_reg;
    end

    always_comb begin
        case (wr_index)
            REG_PHOTO_WIDTH:      prdata = APB_DATA_W'(photo_w_reg);
            REG_PHOTO_HEIGHT:     prdata = APB_DATA_W'(photo_h_reg);
            REG_MARK_WIDTH:       prdata = APB_DATA_W'(mark_w_reg);
            REG_MARK_HEIGHT:      prdata = APB_DATA_W'(mark_h_reg);
            REG_ALIGN_HORIZONTAL: prdata = APB_DATA_W'(align_h_reg);
            REG_ALIGN_VERTICAL:   prdata = APB_DATA_W'(align_v_reg);
            REG_OPACITY_PERCENT:  prdata = APB_DATA_W'(opacity_reg);
            default:              prdata = '0;
        endcase
    end

endmodule

[design/awab_window.sv]
// ----------------------------------------------------------------------------
// awab_window
// registered covered-window bounds per axis, derived from configuration
// ----------------------------------------------------------------------------
module awab_window import awab_pkg::*; (
    input  logic      aclk,
    input  awab_cfg_t cfg,
    output window_t   win
);

    localparam int SW = CFG_DIM_W + 2;

    window_t win_reg, win_next;

    // window is [max(off,0), min(off+m,p)), center offset halves toward zero
    function automatic axis_win_t axis_bounds(input logic [CFG_DIM_W-1:0] plen,
                                              input logic [CFG_DIM_W-1:0] mlen,
                                              input logic [ALIGN_W-1:0]   align);
        logic signed [SW-1:0] p;
        logic signed [SW-1:0] m;
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] off;
        logic signed [SW-1:0] end_pos;
        axis_win_t            r;
        p = $signed({2'b00, plen});
        m = $signed({2'b00, mlen});
        d = p - m;
        case (align)
            ALIGN_MID:  off = (d + $signed({{(SW-1){1'b0}}, d[SW-1]})) >>> 1;
            ALIGN_TAIL: off = d;
            default:    off = '0;
        endcase
        end_pos = off + m;
        r.lo = off[SW-1] ? '0 : off[CFG_DIM_W-1:0];
        r.hi = (end_pos < p) ? end_pos[CFG_DIM_W-1:0] : plen;
        return r;
    endfunction

    always_comb begin
        win_next.x = axis_bounds(cfg.photo_width, cfg.mark_width, cfg.align_horizontal);
        win_next.y = axis_bounds(cfg.photo_height, cfg.mark_height, cfg.align_vertical);
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign win = win_reg;

endmodule

[design/awab_channel.sv]
// ----------------------------------------------------------------------------
// awab_channel
// one color channel: weighted products, reciprocal divide, sum and clamp
// ----------------------------------------------------------------------------
module awab_channel import awab_pkg::*; (
    input  logic                aclk,
    input  stage_en_t           en,
    input  logic [PIX_W-1:0]    photo_s1,
    input  logic [PIX_W-1:0]    mark_s1,
    input  logic [WEIGHT_W-1:0] weight_s1,
    input  logic                cov_s3,
    output logic [PIX_W-1:0]    out_s4
);

    logic [PIX_W-1:0]  photo_s2_reg, photo_s3_reg, out_s4_reg;
    logic [PROD_W-1:0] prod_m_s2_reg, prod_p_s2_reg;
    logic [PIX_W-1:0]  q_m_s3_reg, q_p_s3_reg;
    logic [PROD_W-1:0] prod_m_next, prod_p_next;
    logic [QMUL_W-1:0] qmul_m, qmul_p;
    logic [PIX_W:0]    sum;
    logic [PIX_W-1:0]  out_next;

    assign prod_m_next = PROD_W'(mark_s1) * PROD_W'(weight_s1);
    assign prod_p_next = PROD_W'(photo_s1) * PROD_W'(FULL_SCALE - weight_s1);

    // divide by full scale through the reciprocal
    assign qmul_m = QMUL_W'(prod_m_s2_reg) * QMUL_W'(RECIP);
    assign qmul_p = QMUL_W'(prod_p_s2_reg) * QMUL_W'(RECIP);

    assign sum      = {1'b0, q_m_s3_reg} + {1'b0, q_p_s3_reg};
    assign out_next = !cov_s3 ? photo_s3_reg : (sum[PIX_W] ? '1 : sum[PIX_W-1:0]);

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            photo_s2_reg  <= photo_s1;
            prod_m_s2_reg <= prod_m_next;
            prod_p_s2_reg <= prod_p_next;
        end
        if (en.s3) begin
            photo_s3_reg <= photo_s2_reg;
            q_m_s3_reg   <= qmul_m[SHIFT +: PIX_W];
            q_p_s3_reg   <= qmul_p[SHIFT +: PIX_W];
        end
        if (en.s4) begin
            out_s4_reg <= out_next;
        end
    end

    assign out_s4 = out_s4_reg;

endmodule

[design/aligned_watermark_alpha_blend_top.sv]
// ----------------------------------------------------------------------------
// aligned_watermark_alpha_blend_top
// watermark overlay: aligned window test and per-channel alpha blend
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        payload
//   s_        in         s_valid/s_ready  pixel_x/y, photo rgb, mark rgba
//   m_        out        m_valid/m_ready  out rgb, covered
//   apb       in         psel/penable     seven config registers, 4-byte stride
//
// one beat per cycle sustained while m_ready stays high; four register stages, so a beat
// accepted at s_ reaches m_ after it has passed every stage register
// stages: weight multiply, window test and products, reciprocal divide,
// sum/clamp/select into the output register
// each stage has its own valid bit, so a stall on m_ready only backs up
// through full stages and bubbles close up; nothing is dropped or repeated
// reset clears valid bits, config resets to sizes 1 and opacity 100; no clearing pass
// window bounds are recomputed in the cycle after a register write
//
module aligned_watermark_alpha_blend_top import awab_pkg::*; #(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_W-1:0]    s_pixel_x,
    input  logic [COORD_W-1:0]    s_pixel_y,
    input  logic [PIX_W-1:0]      s_photo_red,
    input  logic [PIX_W-1:0]      s_photo_green,
    input  logic [PIX_W-1:0]      s_photo_blue,
    input  logic [PIX_W-1:0]      s_mark_red,
    input  logic [PIX_W-1:0]      s_mark_green,
    input  logic [PIX_W-1:0]      s_mark_blue,
    input  logic [PIX_W-1:0]      s_mark_alpha,
    // result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIX_W-1:0]      m_out_red,
    output logic [PIX_W-1:0]      m_out_green,
    output logic [PIX_W-1:0]      m_out_blue,
    output logic                  m_covered
);

    awab_cfg_t cfg;
    window_t   win;
    stage_en_t en;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1 payload
    logic [COORD_W-1:0]  x1_reg, y1_reg;
    logic [PIX_W-1:0]    photo_r1_reg, photo_g1_reg, photo_b1_reg;
    logic [PIX_W-1:0]    mark_r1_reg, mark_g1_reg, mark_b1_reg;
    logic [WEIGHT_W-1:0] weight1_reg;
    logic                alpha_nz1_reg;

    // covered flag travels alongside the channel data
    logic cov2_reg, cov3_reg, cov4_reg;
    logic hit_next;

    assign pready = 1'b1;

    awab_cfg #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    awab_window u_window (
        .aclk (aclk),
        .cfg  (cfg),
        .win  (win)
    );

    // a stage can take a beat when empty or when its successor moves
    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign en.s2 = rdy2;
    assign en.s3 = rdy3;
    assign en.s4 = rdy4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: capture the beat and form alpha * opacity
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            x1_reg        <= s_pixel_x;
            y1_reg        <= s_pixel_y;
            photo_r1_reg  <= s_photo_red;
            photo_g1_reg  <= s_photo_green;
            photo_b1_reg  <= s_photo_blue;
            mark_r1_reg   <= s_mark_red;
            mark_g1_reg   <= s_mark_green;
            mark_b1_reg   <= s_mark_blue;
            weight1_reg   <= WEIGHT_W'(s_mark_alpha) * WEIGHT_W'(cfg.opacity_percent);
            alpha_nz1_reg <= (s_mark_alpha != '0);
        end
    end

    // stage 2: window test on both axes and nonzero alpha, pixels outside the photo fall out
    // because the upper bound never passes the photo size
    assign hit_next = alpha_nz1_reg
        && ({1'b0, x1_reg} >= win.x.lo) && ({1'b0, x1_reg} < win.x.hi)
        && ({1'b0, y1_reg} >= win.y.lo) && ({1'b0, y1_reg} < win.y.hi);

    always_ff @(posedge aclk) begin
        if (en.s2) cov2_reg <= hit_next;
        if (en.s3) cov3_reg <= cov2_reg;
        if (en.s4) cov4_reg <= cov3_reg;
    end

    awab_channel u_red (
        .aclk      (aclk),
        .en        (en),
        .photo_s1  (photo_r1_reg),
        .mark_s1   (mark_r1_reg),
        .weight_s1 (weight1_reg),
        .cov_s3    (cov3_reg),
        .out_s4    (m_out_red)
    );

    awab_channel u_green (
        .aclk      (aclk),
        .en        (en),
        .photo_s1  (photo_g1_reg),
        .mark_s1   (mark_g1_reg),
        .weight_s1 (weight1_reg),
        .cov_s3    (cov3_reg),
        .out_s4    (m_out_green)
    );

    awab_channel u_blue (
        .aclk      (aclk),
        .en        (en),
        .photo_s1  (photo_b1_reg),
        .mark_s1   (mark_b1_reg),
        .weight_s1 (weight1_reg),
        .cov_s3    (cov3_reg),
        .out_s4    (m_out_blue)
    );

    assign m_valid   = v4_reg;
    assign m_covered = cov4_reg;

endmodule

[design/awab_checker.sv]
// ----------------------------------------------------------------------------
// awab_checker
// port-level checks on beat flow and output stability
// ----------------------------------------------------------------------------
`include "aligned_watermark_alpha_blend_top_assert.svh"

module awab_checker import awab_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [PIX_W-1:0] m_out_red,
    input logic [PIX_W-1:0] m_out_green,
    input logic [PIX_W-1:0] m_out_blue,
    input logic             m_covered
);

    localparam int DEPTH = 4;

    logic [2:0] inflight_reg, inflight_next;
    logic       in_beat, out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (in_beat && !out_beat) inflight_next = inflight_reg + 3'd1;
        if (!in_beat && out_beat) inflight_next = inflight_reg - 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    `AWAB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_out_red) && $stable(m_out_green) && $stable(m_out_blue) && $stable(m_covered), "result beat changed while stalled")
    `AWAB_ASSERT_NOW(a_no_invented, m_valid, inflight_reg != 3'd0, "result beat with no input beat pending")
    `AWAB_ASSERT_NOW(a_depth, 1'b1, inflight_reg <= 3'(DEPTH), "more beats in flight than pipeline stages")
    `AWAB_ASSERT_NOW(a_stall_source, !s_ready, m_valid, "input stalled while output register empty")

endmodule

bind aligned_watermark_alpha_blend_top awab_checker u_awab_checker (.*);
